@@ rtl/assert_macros.svh @@
// Assertion macros shared by the edge filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ef3_pkg.sv @@
// Types and constants of the 3x3 edge filter.
`timescale 1ns / 1ps
`default_nettype none

package ef3_pkg;

  localparam int PIXEL_W       = 8;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int IMG_W_BITS    = 12;
  localparam int IMG_H_BITS    = 16;
  localparam int MODE_BITS     = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'hFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_WEIGHT = 2'd3;

  // edge modes
  localparam logic [MODE_BITS-1:0] EDGE_H    = 2'd0;
  localparam logic [MODE_BITS-1:0] EDGE_V    = 2'd1;
  localparam logic [MODE_BITS-1:0] EDGE_BOTH = 2'd2;

  localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH   = 12'd640;
  localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT  = 16'd480;
  localparam logic [MODE_BITS-1:0]  RST_EDGE_MODE     = EDGE_BOTH;
  localparam logic [PIXEL_W-1:0]    RST_CENTER_WEIGHT = 8'd60;

  // results one pixel can release, in output order
  localparam int RES_N        = 4;
  localparam int RES_MID      = 0;  // previous row, previous column
  localparam int RES_MID_END  = 1;  // previous row, last column
  localparam int RES_LAST     = 2;  // last row, previous column
  localparam int RES_LAST_END = 3;  // last row, last column

  typedef struct packed {
    logic [IMG_W_BITS-1:0] image_width;
    logic [IMG_H_BITS-1:0] image_height;
    logic [MODE_BITS-1:0]  edge_mode;
    logic [PIXEL_W-1:0]    center_weight;
  } cfg_t;

  // [column: oldest..newest][row: older, newer, current]
  typedef logic [2:0][2:0][PIXEL_W-1:0] window_t;

  typedef struct packed {
    logic             valid;
    logic [RES_N-1:0] mask;
  } job_t;

endpackage

`default_nettype wire

@@ rtl/ef3_stream_if.sv @@
// Valid/ready stream interfaces for the pixel and edge words.
`timescale 1ns / 1ps
`default_nettype none

interface ef3_pixel_if;
  import ef3_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface ef3_edge_if;
  import ef3_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] edge_value;
  logic               row_end;
  logic               frame_end;

  modport source (output valid, output edge_value, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input edge_value, input row_end, input frame_end,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/edge_filter_3x3_unit.sv @@
// Top level of the streaming 3x3 gradient edge filter with its register file.
// Usage:
//   pixels : sink channel, one 8-bit grayscale word per transfer, raster order.
//   edges  : source channel, one edge magnitude word per output pixel, with
//            row_end on the last word of a row and frame_end on the last of
//            the frame.
//   wr_en/wr_index/wr_data : register writes (width, height, mode, weight),
//            to be done only while no frame is in flight.
// The input accepts a word every cycle while the output keeps up. An output
// word depends on the pixel one row and one column later, so edges lag the
// input by a row plus a pixel. Once its last input has been accepted, a word
// passes the input stage, then the tap window and result sequencer, then the
// output register. A row end pixel releases up to two words and pixels of the
// last row release up to four, one per cycle from the result sequencer while
// the output is free; input stalls while they are sent.
// A stalled receiver fills the output register, then the sequencer, then the
// input stage, and pixels.ready drops; nothing is lost.
// Reset (rst, synchronous) loads the default registers and restarts at row 0,
// column 0. Row stores need no clearing: the first row seeds them.
`timescale 1ns / 1ps
`default_nettype none

module edge_filter_3x3_unit #(
  parameter int MAX_WIDTH = ef3_pkg::DEF_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [ef3_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [ef3_pkg::CFG_DATA_W-1:0] wr_data,
  ef3_pixel_if.sink                      pixels,
  ef3_edge_if.source                     edges
);
  import ef3_pkg::*;

  cfg_t    cfg;
  window_t window;
  job_t    job;
  logic    job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= RST_IMAGE_WIDTH;
      cfg.image_height  <= RST_IMAGE_HEIGHT;
      cfg.edge_mode     <= RST_EDGE_MODE;
      cfg.center_weight <= RST_CENTER_WEIGHT;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_IMAGE_WIDTH:   cfg.image_width   <= wr_data[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT:  cfg.image_height  <= wr_data[IMG_H_BITS-1:0];
        REG_EDGE_MODE:     cfg.edge_mode     <= wr_data[MODE_BITS-1:0];
        REG_CENTER_WEIGHT: cfg.center_weight <= wr_data[PIXEL_W-1:0];
      endcase
    end
  end

  ef3_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pixels    (pixels),
    .window    (window),
    .job       (job),
    .job_ready (job_ready)
  );

  ef3_kernel u_kernel (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .window    (window),
    .job       (job),
    .job_ready (job_ready),
    .edges     (edges)
  );

endmodule

`default_nettype wire

@@ rtl/ef3_scan.sv @@
// Raster position tracking, two row stores and the 3x3 tap window.
`timescale 1ns / 1ps
`default_nettype none

module ef3_scan #(
  parameter int MAX_WIDTH = ef3_pkg::DEF_MAX_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  ef3_pkg::cfg_t    cfg,
  ef3_pixel_if.sink        pixels,
  output ef3_pkg::window_t window,
  output ef3_pkg::job_t    job,
  input  logic             job_ready
);
  import ef3_pkg::*;

  `include "assert_macros.svh"

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int XW = ((CW > IMG_W_BITS) ? CW : IMG_W_BITS) + 1;
  localparam int RW = IMG_H_BITS + 1;

  logic [CW-1:0]         col;
  logic [IMG_H_BITS-1:0] row;

  logic [XW-1:0] w_raw, w_eff, x_ext, x_clamp;
  logic [RW-1:0] h_raw, h_eff;
  logic [CW-1:0] addr;
  logic          row_end, last_row, in_fire, s1_adv;
  logic [RES_N-1:0] mask;

  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_pixel;
  logic [CW-1:0]      s1_addr;
  logic               s1_row0;
  logic [RES_N-1:0]   s1_mask;

  logic [PIXEL_W-1:0] mem_older [MAX_WIDTH];
  logic [PIXEL_W-1:0] mem_newer [MAX_WIDTH];
  logic [PIXEL_W-1:0] rd_older, rd_newer;
  logic               fwd_hit;
  logic [PIXEL_W-1:0] fwd_older, fwd_newer;
  logic [PIXEL_W-1:0] cur_o, cur_n;

  window_t taps;

  // geometry, with zero values and an oversize width clamped
  assign w_raw = XW'(cfg.image_width);
  assign h_raw = RW'(cfg.image_height);
  assign x_ext = XW'(col);

  always_comb begin
    w_eff = w_raw;
    if (w_raw == '0) begin
      w_eff = XW'(1);
    end else if (w_raw > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end
    h_eff   = (h_raw == '0) ? RW'(1) : h_raw;
    x_clamp = (x_ext >= XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH - 1) : x_ext;
  end

  assign addr     = x_clamp[CW-1:0];
  assign row_end  = (x_clamp + XW'(1)) >= w_eff;
  assign last_row = (RW'(row) + RW'(1)) >= h_eff;

  assign mask[RES_MID]      = (row != '0) && (addr != '0);
  assign mask[RES_MID_END]  = (row != '0) && row_end;
  assign mask[RES_LAST]     = last_row && (addr != '0);
  assign mask[RES_LAST_END] = last_row && row_end;

  assign s1_adv       = s1_valid && job_ready;
  assign pixels.ready = !s1_valid || job_ready;
  assign in_fire      = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        if (row_end) begin
          col <= '0;
          row <= last_row ? '0 : row + IMG_H_BITS'(1);
        end else begin
          col <= addr + CW'(1);
        end
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel <= pixels.pixel;
      s1_addr  <= addr;
      s1_row0  <= (row == '0);
      s1_mask  <= mask;
    end
  end

  // row stores: read on accept, written when the word leaves the input stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_older <= mem_older[addr];
      rd_newer <= mem_newer[addr];
    end
    if (s1_adv) begin
      mem_older[s1_addr] <= cur_n;
      mem_newer[s1_addr] <= s1_pixel;
    end
  end

  // bypass for a read that meets the write of the previous word
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (in_fire) begin
      fwd_hit <= s1_adv && (s1_addr == addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_older <= cur_n;
      fwd_newer <= s1_pixel;
    end
  end

  // first row replicates upward
  assign cur_o = s1_row0 ? s1_pixel : (fwd_hit ? fwd_older : rd_older);
  assign cur_n = s1_row0 ? s1_pixel : (fwd_hit ? fwd_newer : rd_newer);

  always_ff @(posedge clk) begin
    if (rst) begin
      taps <= '0;
    end else if (s1_adv) begin
      if (s1_addr == '0) begin
        for (int c = 0; c < 3; c++) begin
          taps[c] <= {s1_pixel, cur_n, cur_o};
        end
      end else begin
        taps[0] <= taps[1];
        taps[1] <= taps[2];
        taps[2] <= {s1_pixel, cur_n, cur_o};
      end
    end
  end

  assign window    = taps;
  assign job.valid = s1_valid;
  assign job.mask  = s1_mask;

  `ASSERT_NOW(a_row0_no_mid_results, s1_valid && s1_row0, (s1_mask[RES_MID] == 1'b0) && (s1_mask[RES_MID_END] == 1'b0), "first row released a previous-row result")
  `ASSERT_NOW(a_bypass_same_addr, fwd_hit, s1_addr == $past(s1_addr), "row store bypass on a different address")
  `ASSERT_NEXT(a_row_end_wraps, in_fire && row_end, col == '0, "column index did not wrap at row end")

endmodule

`default_nettype wire

@@ rtl/ef3_kernel.sv @@
// Result sequencer, gradient arithmetic and output register.
`timescale 1ns / 1ps
`default_nettype none

module ef3_kernel (
  input  logic             clk,
  input  logic             rst,
  input  ef3_pkg::cfg_t    cfg,
  input  ef3_pkg::window_t window,
  input  ef3_pkg::job_t    job,
  output logic             job_ready,
  ef3_edge_if.source       edges
);
  import ef3_pkg::*;

  `include "assert_macros.svh"

  logic [RES_N-1:0] pend, sel;
  logic             out_free, seq_fire, job_load;
  logic             shift_col, shift_row;
  logic [1:0]       top_i, mid_i;

  logic [2:0][PIXEL_W-1:0] c_l, c_c, c_r;
  logic [PIXEL_W-1:0] tl, tc, tr, ml, mr, bl, bc, br;

  logic signed [9:0]  h_side, v_side;
  logic signed [8:0]  h_diff, v_diff, weight_s;
  logic signed [17:0] h_prod, v_prod, gh, gv;
  logic [17:0]        abs_h, abs_v;
  logic [12:0]        mag_h, mag_v;
  logic [13:0]        mag;
  logic [PIXEL_W-1:0] sat;

  // lowest pending result goes out first
  assign sel       = pend & (~pend + RES_N'(1));
  assign out_free  = !edges.valid || edges.ready;
  assign seq_fire  = (pend != '0) && out_free;
  assign job_ready = (pend == '0) || ((pend == sel) && seq_fire);
  assign job_load  = job.valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (job_load) begin
      pend <= job.mask;
    end else if (seq_fire) begin
      pend <= pend & ~sel;
    end
  end

  // last column and last row replicate outward
  assign shift_col = sel[RES_MID_END] || sel[RES_LAST_END];
  assign shift_row = sel[RES_LAST] || sel[RES_LAST_END];
  assign top_i     = shift_row ? 2'd1 : 2'd0;
  assign mid_i     = shift_row ? 2'd2 : 2'd1;

  assign c_l = shift_col ? window[1] : window[0];
  assign c_c = shift_col ? window[2] : window[1];
  assign c_r = window[2];

  assign tl = c_l[top_i];
  assign tc = c_c[top_i];
  assign tr = c_r[top_i];
  assign ml = c_l[mid_i];
  assign mr = c_r[mid_i];
  assign bl = c_l[2];
  assign bc = c_c[2];
  assign br = c_r[2];

  assign h_side   = $signed({2'b00, tl} + {2'b00, tr} - {2'b00, bl} - {2'b00, br});
  assign v_side   = $signed({2'b00, tl} + {2'b00, bl} - {2'b00, tr} - {2'b00, br});
  assign h_diff   = $signed({1'b0, tc} - {1'b0, bc});
  assign v_diff   = $signed({1'b0, ml} - {1'b0, mr});
  assign weight_s = $signed({1'b0, cfg.center_weight});

  assign h_prod = weight_s * h_diff;
  assign v_prod = weight_s * v_diff;
  assign gh     = h_prod + 18'(h_side);
  assign gv     = v_prod + 18'(v_side);

  assign abs_h = gh[17] ? 18'(-gh) : 18'(gh);
  assign abs_v = gv[17] ? 18'(-gv) : 18'(gv);
  assign mag_h = abs_h[15:3];
  assign mag_v = abs_v[15:3];

  always_comb begin
    unique case (cfg.edge_mode)
      EDGE_H:  mag = {1'b0, mag_h};
      EDGE_V:  mag = {1'b0, mag_v};
      default: mag = 14'(mag_h) + 14'(mag_v);
    endcase
  end

  assign sat = (mag > 14'(PIXEL_MAX)) ? PIXEL_MAX : mag[PIXEL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      edges.valid <= 1'b0;
    end else if (seq_fire) begin
      edges.valid <= 1'b1;
    end else if (edges.ready) begin
      edges.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_fire) begin
      edges.edge_value <= sat;
      edges.row_end    <= shift_col;
      edges.frame_end  <= sel[RES_LAST_END];
    end
  end

  `ASSERT_NOW(a_frame_end_on_row_end, edges.valid && edges.frame_end, edges.row_end, "frame end word without row end")
  `ASSERT_NOW(a_no_pending_dropped, job_load && (pend != '0), seq_fire && (pend == sel), "new window loaded over pending results")
  `ASSERT_NEXT(a_one_result_per_step, seq_fire && !job_load, ($countones(pend) + 1) == $past($countones(pend)), "sequencer did not retire exactly one result")

endmodule

`default_nettype wire

@@ tb/sv/edge_filter_3x3_unit_tb.sv @@
// Self-checking testbench: streams frames through the 3x3 edge filter and checks each edge word.
`timescale 1ns / 1ps

module edge_filter_3x3_unit_tb;
  import ef3_pkg::*;

  localparam int MAX_WIDTH    = DEF_MAX_WIDTH;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 60;
  localparam int REPORT_MAX   = 10;

  localparam logic [MODE_BITS-1:0] EDGE_MODE_THREE = 2'd3;

  localparam int PAT_NOISE   = 0;
  localparam int PAT_EXTREME = 1;
  localparam int PAT_RAMP    = 2;
  localparam int PAT_SPIKE   = 3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] edge_value;
    logic               row_end;
    logic               frame_end;
  } edge_word_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  ef3_pixel_if pix_if ();
  ef3_edge_if  edge_if ();

  edge_filter_3x3_unit #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pixels   (pix_if),
    .edges    (edge_if)
  );

  always #5 clk = ~clk;

  // shadow of the filter
  cfg_t                  shadow_cfg;
  logic [PIXEL_W-1:0]    older_line [MAX_WIDTH];
  logic [PIXEL_W-1:0]    newer_line [MAX_WIDTH];
  logic [PIXEL_W-1:0]    window [3][3];  // [column][row]
  logic [COL_BITS-1:0]   col_pos;
  logic [IMG_H_BITS-1:0] row_pos;

  logic [PIXEL_W-1:0] pending_pixels [$];
  edge_word_t         expected_edges [$];

  int         send_gap_pct;
  int         recv_stall_pct;
  int         fail_count;
  int         cycle_count;
  bit         pix_taken;
  edge_word_t seen_word;
  edge_word_t wanted_word;

  function automatic logic [PIXEL_W-1:0] edge_mag(input int c0, input int c1, input int c2,
                                                  input int r0, input int r1, input int r2);
    int wt;
    int gh;
    int gv;
    int mh;
    int mv;
    int sum;
    wt = int'(shadow_cfg.center_weight);
    gh = (int'(window[c0][r0]) + wt * int'(window[c1][r0]) + int'(window[c2][r0]))
       - (int'(window[c0][r2]) + wt * int'(window[c1][r2]) + int'(window[c2][r2]));
    gv = (int'(window[c0][r0]) + wt * int'(window[c0][r1]) + int'(window[c0][r2]))
       - (int'(window[c2][r0]) + wt * int'(window[c2][r1]) + int'(window[c2][r2]));
    mh = ((gh < 0) ? -gh : gh) >> 3;
    mv = ((gv < 0) ? -gv : gv) >> 3;
    case (shadow_cfg.edge_mode)
      EDGE_H: sum = mh;
      EDGE_V: sum = mv;
      default: sum = mh + mv;
    endcase
    return (sum > int'(PIXEL_MAX)) ? PIXEL_MAX : PIXEL_W'(sum);
  endfunction

  task automatic push_edge(input logic [PIXEL_W-1:0] value, input logic re, input logic fe);
    expected_edges.push_back({value, re, fe});
  endtask

  task automatic predict_edges(input logic [PIXEL_W-1:0] p);
    int                 w;
    int                 h;
    int                 x;
    logic [PIXEL_W-1:0] o;
    logic [PIXEL_W-1:0] n;
    logic               at_row_end;
    logic               at_last_row;
    w = int'(shadow_cfg.image_width);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = int'(shadow_cfg.image_height);
    if (h == 0) h = 1;
    x = int'(col_pos);
    if (x >= MAX_WIDTH) x = MAX_WIDTH - 1;
    at_row_end  = (x + 1 >= w);
    at_last_row = (int'(row_pos) + 1 >= h);
    if (row_pos == '0) begin
      o = p;
      n = p;
    end else begin
      o = older_line[x];
      n = newer_line[x];
    end
    older_line[x] = n;
    newer_line[x] = p;
    if (x == 0) begin
      for (int c = 0; c < 3; c++) begin
        window[c][0] = o;
        window[c][1] = n;
        window[c][2] = p;
      end
    end else begin
      for (int r = 0; r < 3; r++) begin
        window[0][r] = window[1][r];
        window[1][r] = window[2][r];
      end
      window[2][0] = o;
      window[2][1] = n;
      window[2][2] = p;
    end
    if (row_pos != '0) begin
      if (x >= 1) push_edge(edge_mag(0, 1, 2, 0, 1, 2), 1'b0, 1'b0);
      if (at_row_end) push_edge(edge_mag(1, 2, 2, 0, 1, 2), 1'b1, 1'b0);
    end
    if (at_last_row) begin
      if (x >= 1) push_edge(edge_mag(0, 1, 2, 1, 2, 2), 1'b0, 1'b0);
      if (at_row_end) push_edge(edge_mag(1, 2, 2, 1, 2, 2), 1'b1, 1'b1);
    end
    if (at_row_end) begin
      col_pos = '0;
      row_pos = at_last_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = COL_BITS'(x + 1);
    end
  endtask

  task automatic report_failure(input string what, input bit has_want);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      if (has_want)
        $display("%s: expected %0d re %0b fe %0b, actual %0d re %0b fe %0b",
                 what, wanted_word.edge_value, wanted_word.row_end, wanted_word.frame_end,
                 seen_word.edge_value, seen_word.row_end, seen_word.frame_end);
      else
        $display("%s: expected none, actual %0d re %0b fe %0b",
                 what, seen_word.edge_value, seen_word.row_end, seen_word.frame_end);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_taken) begin
      if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        pix_if.valid <= 1'b1;
        pix_if.pixel <= pending_pixels.pop_front();
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    edge_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor: output words first, then the accepted pixel
  always @(posedge clk) begin
    cycle_count++;
    if (rst) begin
      pix_taken = 1'b0;
    end else begin
      if (edge_if.valid && edge_if.ready) begin
        seen_word = {edge_if.edge_value, edge_if.row_end, edge_if.frame_end};
        if (expected_edges.size() == 0) begin
          report_failure("edge word with no pending result", 1'b0);
        end else begin
          wanted_word = expected_edges.pop_front();
          if (seen_word.edge_value !== wanted_word.edge_value ||
              seen_word.row_end !== wanted_word.row_end ||
              seen_word.frame_end !== wanted_word.frame_end)
            report_failure("edge word mismatch", 1'b1);
        end
      end
      pix_taken = pix_if.valid && pix_if.ready;
      if (pix_taken) predict_edges(pix_if.pixel);
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_gap_pct = 67; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_gap_pct = 0;  recv_stall_pct = 67; end
      IDLE_BOTH: begin send_gap_pct = 32; recv_stall_pct = 32; end
    endcase
  endtask

  task automatic wait_idle();
    bit settled;
    settled = 1'b0;
    while (!settled) begin
      @(posedge clk);
      if (pending_pixels.size() == 0 && !pix_if.valid) begin
        @(negedge clk);
        settled = (expected_edges.size() == 0);
      end
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= CFG_DATA_W'(value);
    case (idx)
      REG_IMAGE_WIDTH:   shadow_cfg.image_width   = value[IMG_W_BITS-1:0];
      REG_IMAGE_HEIGHT:  shadow_cfg.image_height  = value[IMG_H_BITS-1:0];
      REG_EDGE_MODE:     shadow_cfg.edge_mode     = value[MODE_BITS-1:0];
      REG_CENTER_WEIGHT: shadow_cfg.center_weight = value[PIXEL_W-1:0];
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic configure(input int width, input int height, input int mode, input int weight);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, width);
    write_reg(REG_IMAGE_HEIGHT, height);
    write_reg(REG_EDGE_MODE, mode);
    write_reg(REG_CENTER_WEIGHT, weight);
  endtask

  function automatic logic [PIXEL_W-1:0] gen_pixel(input int pattern, input int k);
    case (pattern)
      PAT_EXTREME: return ($urandom_range(0, 1) != 0) ? PIXEL_MAX : '0;
      PAT_RAMP:    return PIXEL_W'(k * 13 + $urandom_range(0, 15));
      PAT_SPIKE:   return ($urandom_range(0, 15) == 0) ? PIXEL_W'($urandom_range(0, 255))
                                                       : PIXEL_W'(120 + $urandom_range(0, 7));
      default:     return PIXEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_pixels(input int count, input int pattern);
    @(posedge clk);
    for (int k = 0; k < count; k++) pending_pixels.push_back(gen_pixel(pattern, k));
  endtask

  function automatic int clamp_dim(input int v, input int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return int'(PIXEL_MAX);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  initial begin
    int w;
    int h;
    int sent;
    rst            = 1'b1;
    wr_en          = 1'b0;
    wr_index       = '0;
    wr_data        = '0;
    pix_if.valid   = 1'b0;
    pix_if.pixel   = '0;
    edge_if.ready  = 1'b0;
    fail_count     = 0;
    cycle_count    = 0;
    pix_taken      = 1'b0;
    shadow_cfg     = {RST_IMAGE_WIDTH, RST_IMAGE_HEIGHT, RST_EDGE_MODE, RST_CENTER_WEIGHT};
    col_pos        = '0;
    row_pos        = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++) window[c][r] = '0;
    set_idle(IDLE_NONE);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero geometry acts as a single pixel
    configure(0, 0, EDGE_H, 0);
    @(posedge clk);
    pending_pixels.push_back(PIXEL_MAX);

    configure(1, 3, EDGE_V, int'(PIXEL_MAX));
    @(posedge clk);
    pending_pixels.push_back('0);
    pending_pixels.push_back(PIXEL_MAX);
    pending_pixels.push_back('0);

    // checkerboard under full weight saturates on the border and cancels inside; mode three sums both
    configure(4, 4, EDGE_MODE_THREE, int'(PIXEL_MAX));
    @(posedge clk);
    for (int y = 0; y < 4; y++)
      for (int x = 0; x < 4; x++) pending_pixels.push_back(((x + y) % 2 != 0) ? PIXEL_MAX : '0);

    configure(2, 2, EDGE_BOTH, int'(RST_CENTER_WEIGHT));
    @(posedge clk);
    pending_pixels.push_back(PIXEL_MAX);
    pending_pixels.push_back('0);
    pending_pixels.push_back('0);
    pending_pixels.push_back(PIXEL_MAX);

    for (int phase = 0; phase < 4; phase++) begin
      set_idle(idle_mode_t'(phase));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0: w = 0;
          1: w = 1;
          default: w = $urandom_range(2, 12);
        endcase
        h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
        configure(w, h, $urandom_range(0, 3), pick_weight());
        repeat ($urandom_range(1, 2)) begin
          queue_pixels(clamp_dim(w, MAX_WIDTH) * clamp_dim(h, 65535), $urandom_range(0, 3));
          sent += clamp_dim(w, MAX_WIDTH) * clamp_dim(h, 65535);
        end
      end
    end

    // geometry shrunk mid-frame: width cut mid-row, then height cut to end the frame
    set_idle(IDLE_BOTH);
    configure(8, 65535, EDGE_BOTH, pick_weight());
    queue_pixels(8 * 3 + 3, PAT_NOISE);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 2);
    queue_pixels(1 + 2 * 2, PAT_EXTREME);
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, 3);
    queue_pixels(2, PAT_NOISE);

    // width past the row store limit: a single-row frame, first part of the row
    set_idle(IDLE_NONE);
    configure(4095, 1, $urandom_range(0, 3), pick_weight());
    queue_pixels(24, PAT_NOISE);

    wait_idle();
    if (expected_edges.size() != 0) fail_count += expected_edges.size();
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ef3_pkg.sv
rtl/ef3_stream_if.sv
rtl/ef3_scan.sv
rtl/ef3_kernel.sv
rtl/edge_filter_3x3_unit.sv
tb/sv/edge_filter_3x3_unit_tb.sv
